[rtl/core/lpsa_pkg.sv]
// ----------------------------------------------------------------------------
// lpsa_pkg
// Shared types and constants for the linear-probe slot allocator: beat
// payloads, sequencer states and table geometry.
// ----------------------------------------------------------------------------
package lpsa_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 31;
    localparam int SIZE_W      = 11;
    localparam int SLOT_W      = 10;
    localparam int ROW_W       = 32;
    localparam int BIT_IDX_W   = $clog2(ROW_W);
    localparam int ROWS        = TABLE_DEPTH / ROW_W;
    localparam int ROW_IDX_W   = $clog2(ROWS);
    localparam int VISIT_W     = ROW_IDX_W + 1;
    localparam int DIV_CNT_W   = $clog2(KEY_W);

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(TABLE_DEPTH);

    typedef struct packed {
        logic [KEY_W-1:0] user_id;
        logic             last_of_batch;
    } t_lpsa_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              table_full;
    } t_lpsa_res;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } t_lpsa_div_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK
    } t_lpsa_state;

endpackage

[rtl/core/linear_probe_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// linear_probe_slot_allocator_unit
// Open-addressing slot allocator with linear probing over an occupancy
// bitmap held as rows of 32 marks, one row read per probe step.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   i_req                         start & !busy
//  result    o_res                         o_res_vld, one cycle, no stall
//  config    i_cfg_wdata (table_size)      i_cfg_we
//
//  Each beat passes through the remainder unit, then the remainder is taken,
//  then there is one read and one check step per bitmap row probed (1 to
//  ceil(size/32)+1 rows) through the single bitmap port.
//  busy is high from acceptance until the result cycle; the next beat may be
//  taken in the cycle the result is shown.
//  Reset is synchronous; it and any last-of-batch beat clear the per-row
//  valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_probe_slot_allocator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lpsa_pkg::t_lpsa_req            i_req,
    output logic                           o_res_vld,
    output lpsa_pkg::t_lpsa_res            o_res,
    input  logic                           i_cfg_we,
    input  logic [lpsa_pkg::SIZE_W-1:0]    i_cfg_wdata
);
    import lpsa_pkg::*;

    t_lpsa_state          r_state, n_state;
    logic [SIZE_W-1:0]    r_cfg_size;
    logic [SIZE_W-1:0]    r_size;
    logic [VISIT_W-1:0]   r_nrows;
    logic [VISIT_W-1:0]   r_visits, n_visits;
    logic [SLOT_W-1:0]    r_pos, n_pos;
    logic                 r_last;
    logic [ROWS-1:0]      r_row_vld;
    logic [ROW_W-1:0]     r_rd_data;
    logic [ROW_W-1:0]     mem [ROWS];
    logic                 r_res_vld, n_res_vld;
    t_lpsa_res            r_res, n_res;

    logic                 accept;
    logic [SIZE_W-1:0]    eff_size;
    t_lpsa_div_stat       div_stat;
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_W-1:0]     word;
    logic [ROW_W-1:0]     free;
    logic                 found;
    logic [BIT_IDX_W-1:0] idx;
    logic [VISIT_W-1:0]   next_row;
    logic [SIZE_W-1:0]    next_start;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_data;
    logic                 clr;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        priority if (r_cfg_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_cfg_size > SIZE_W'(TABLE_DEPTH)) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            eff_size = r_cfg_size;
        end
    end

    lpsa_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_req.user_id),
        .i_divisor  (eff_size),
        .o_stat     (div_stat)
    );

    // Probe one row: free marks at or after the probe point and inside the size
    always_comb begin
        row  = r_pos[SLOT_W-1:BIT_IDX_W];
        word = r_row_vld[row] ? r_rd_data : '0;
        for (int i = 0; i < ROW_W; i++) begin
            free[i] = !word[i] && (BIT_IDX_W'(i) >= r_pos[BIT_IDX_W-1:0])
                      && ({1'b0, row, BIT_IDX_W'(i)} < r_size);
        end
        found = |free;
        idx   = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (free[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        next_row   = {1'b0, row} + 1'b1;
        next_start = {next_row, {BIT_IDX_W{1'b0}}};
        wr_data    = word | (ROW_W'(1) << idx);
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_visits  = r_visits;
        n_res_vld = 1'b0;
        n_res     = r_res;
        wr_en     = 1'b0;
        clr       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_stat.done) begin
                    n_pos    = div_stat.rem[SLOT_W-1:0];
                    n_visits = '0;
                    n_state  = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_visits = r_visits + 1'b1;
                priority if (found) begin
                    wr_en            = 1'b1;
                    n_res.slot       = {row, idx};
                    n_res.table_full = 1'b0;
                    n_res_vld        = 1'b1;
                    clr              = r_last;
                    n_state          = ST_IDLE;
                end else if (r_visits == r_nrows) begin
                    n_res.slot       = '0;
                    n_res.table_full = 1'b1;
                    n_res_vld        = 1'b1;
                    clr              = r_last;
                    n_state          = ST_IDLE;
                end else begin
                    // advance to the next row start, wrap at the size
                    n_pos   = (next_start >= r_size) ? '0 : next_start[SLOT_W-1:0];
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= TABLE_SIZE_RESET;
            r_row_vld  <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_size <= i_cfg_wdata;
            end
            r_res_vld <= n_res_vld;
            // drop the whole table after the last beat of a batch
            if (clr) begin
                r_row_vld <= '0;
            end else if (wr_en) begin
                r_row_vld[row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_size  <= eff_size;
            r_nrows <= VISIT_W'((eff_size + SIZE_W'(ROW_W - 1)) >> BIT_IDX_W);
            r_last  <= i_req.last_of_batch;
        end
        r_pos    <= n_pos;
        r_visits <= n_visits;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd_data <= mem[row];
        end
        if (wr_en) begin
            mem[row] <= wr_data;
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    a_res_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> $past(r_state == ST_CHECK))
        else $error("result strobe without a preceding probe check");

    a_accept_to_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MOD))
        else $error("accepted beat did not enter the remainder step");

    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.table_full) |-> (o_res.slot == '0))
        else $error("full table result carries a non-zero slot");

    a_slot_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && !o_res.table_full) |-> ({1'b0, o_res.slot} < r_size))
        else $error("allocated slot lies outside the table size");

    a_pos_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> ({1'b0, r_pos} < r_size))
        else $error("probe position outside the table size");

endmodule

[rtl/core/lpsa_mod_unit.sv]
// ----------------------------------------------------------------------------
// lpsa_mod_unit
// Restoring remainder unit: one quotient bit per cycle, reporting the
// remainder of key modulo size.
// ----------------------------------------------------------------------------
module lpsa_mod_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lpsa_pkg::KEY_W-1:0]     i_dividend,
    input  logic [lpsa_pkg::SIZE_W-1:0]    i_divisor,
    output lpsa_pkg::t_lpsa_div_stat       o_stat
);
    import lpsa_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_quo;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_div;

    logic [SIZE_W-1:0]    rem_sh;
    logic [SIZE_W:0]      diff;
    logic [SIZE_W-1:0]    n_rem;

    always_comb begin
        rem_sh = {r_rem[SIZE_W-2:0], r_quo[KEY_W-1]};
        diff   = {1'b0, rem_sh} - {1'b0, r_div};
        n_rem  = diff[SIZE_W] ? rem_sh : diff[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule
